FILE: sv/tpbb_pkg.sv
// tpbb_pkg: shared types and constants for the two-pass box blur
// request/result payload structs, config register indexes, sequencer states
// no dependencies
package tpbb_pkg;

  localparam int PIX_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_in;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             valid_res;
    logic             last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_DSTART,
    ST_DIV,
    ST_WRITE
  } blur_state_t;

endpackage

FILE: sv/tpbb_div.sv
// tpbb_div: three-channel restoring divider, one quotient bit per cycle
// divides window sums by the window span; quotient fits in 8 bits
// depends on nothing but its parameters
module tpbb_div #(
  parameter int SUM_W = 13,
  parameter int DEN_W = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DEN_W-1:0]      den,
  input  logic [2:0][SUM_W-1:0] num,
  output logic [2:0][7:0]       quo,
  output logic                  done
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [2:0][SUM_W-1:0] q;
  logic [2:0][DEN_W:0]   rem;
  logic [2:0][DEN_W:0]   rem_sh;
  logic [CNT_W-1:0]      cnt;
  logic                  run;

  // one restoring step per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem_sh[c] = {rem[c][DEN_W-1:0], q[c][SUM_W-1]};
    end
  end

  // control: count steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(SUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift numerator in, subtract when it fits
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (start) begin
        q[c]   <= num[c];
        rem[c] <= '0;
      end else if (run) begin
        if (rem_sh[c] >= {1'b0, den}) begin
          rem[c] <= rem_sh[c] - {1'b0, den};
          q[c]   <= {q[c][SUM_W-2:0], 1'b1};
        end else begin
          rem[c] <= rem_sh[c];
          q[c]   <= {q[c][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quo[c] = q[c][7:0];
    end
  end

endmodule

FILE: sv/two_pass_box_blur.sv
// two_pass_box_blur: frame store, blur sequencer and readout
// uses tpbb_pkg for payload types and states, tpbb_div for window averages
//
// Usage: a request is taken when start is high and busy is low. A load
// request (mode 0) writes one pixel in raster order; the load that
// completes image_width x image_height pixels starts the blur. A fetch
// request (mode 1) returns one result on res in the next cycle, marked by
// res_strobe for exactly one cycle; the receiver cannot stall it. Fetches
// before the blur is done return valid_res 0. Loads during readout are
// dropped. After the pixel flagged last the block returns to loading.
// Loads and fetches stream at one per cycle while busy is low. The blur
// is a burst with busy high: per pass and direction each pixel takes
// (2*radius+1) store reads, a drain, a divider hand-off, the bit-serial
// divide and one write; its speed is set by the single read port of each
// store and the bit-serial divider. Config writes go over cfg_valid and
// cfg_ready (always ready); the user must send them only while idle, unchecked.
// Reset clears the control state; store contents stay undefined.
module two_pass_box_blur
  import tpbb_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_RADIUS = 15,
  parameter int PASSES     = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 res_strobe,
  output res_t                 res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = (XW > YW) ? XW : YW;
  localparam int RW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int DEN_W = $clog2(2 * MAX_RADIUS + 2);
  localparam int SUM_W = 8 + DEN_W;
  localparam int KW    = PW + RW + 1;
  localparam int PSW   = $clog2(PASSES + 1);

  // config registers
  logic [7:0] cfg_w, cfg_h;
  logic [3:0] cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= 8'd128;
      cfg_h <= 8'd128;
      cfg_r <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_w <= cfg_data;
        CFG_HEIGHT: cfg_h <= cfg_data;
        CFG_RADIUS: cfg_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // effective sizes, saturated to the store
  logic [PW-1:0] eff_w, eff_h;
  logic [RW-1:0] eff_r;
  logic [CW-1:0] total;

  always_comb begin
    if (cfg_w == 8'd0)                 eff_w = PW'(1);
    else if (32'(cfg_w) > MAX_WIDTH)   eff_w = PW'(MAX_WIDTH);
    else                               eff_w = PW'(cfg_w);
    if (cfg_h == 8'd0)                 eff_h = PW'(1);
    else if (32'(cfg_h) > MAX_HEIGHT)  eff_h = PW'(MAX_HEIGHT);
    else                               eff_h = PW'(cfg_h);
    if (32'(cfg_r) > MAX_RADIUS)       eff_r = RW'(MAX_RADIUS);
    else                               eff_r = RW'(cfg_r);
    total = CW'(eff_w) * CW'(eff_h);
  end

  // control state
  blur_state_t      state, state_next;
  logic             readout;
  logic [CW-1:0]    load_count, read_count;
  logic [PW-1:0]    bw, bh, x, y;
  logic [RW-1:0]    br;
  logic             dir;
  logic [PSW-1:0]   pass;
  logic [CW-1:0]    row_base;
  logic signed [KW-1:0] k, kend;
  logic             rd_pend;
  logic [2:0][SUM_W-1:0] sum;

  logic accept, do_load, do_fetch;
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign do_load  = accept && (req.mode == MODE_LOAD) && !readout;
  assign do_fetch = accept && (req.mode == MODE_FETCH);

  // load bookkeeping
  logic          load_room, frame_full;
  logic [CW-1:0] load_count_next;
  assign load_room       = (load_count < total);
  assign load_count_next = load_room ? load_count + 1'b1 : load_count;
  assign frame_full      = (load_count_next >= total);

  // fetch index and last flag
  logic [CW-1:0] fetch_idx;
  logic          fetch_last;
  assign fetch_idx  = (read_count < total) ? read_count : total - 1'b1;
  assign fetch_last = ({1'b0, read_count} + 1'b1) >= {1'b0, total};

  // clamped sample index and source address
  logic [PW-1:0] n, kc;
  logic [CW-1:0] src_addr, dst_addr;

  always_comb begin
    n = dir ? bh : bw;
    if (k < 0)                         kc = '0;
    else if (k >= $signed(KW'(n)))     kc = n - 1'b1;
    else                               kc = PW'(k);
    src_addr = dir ? CW'(x) + CW'(kc) * CW'(bw) : row_base + CW'(kc);
    dst_addr = row_base + CW'(x);
  end

  // stores: frame holds the image and each vertical result,
  // pass holds the horizontal result
  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [PIX_W-1:0] pass_mem  [DEPTH];
  logic [PIX_W-1:0] frame_q, pass_q;
  logic [AW-1:0]    frame_raddr, frame_waddr;
  logic [PIX_W-1:0] frame_wdata;
  logic             frame_we, pass_we;
  logic [2:0][7:0]  quo;

  always_comb begin
    frame_raddr = (state == ST_ACC && !dir) ? src_addr[AW-1:0] : fetch_idx[AW-1:0];
    frame_we    = do_load ? load_room : (state == ST_WRITE && dir);
    frame_waddr = do_load ? load_count[AW-1:0] : dst_addr[AW-1:0];
    frame_wdata = do_load ? req.pixel_in : {quo[2], quo[1], quo[0]};
    pass_we     = (state == ST_WRITE) && !dir;
  end

  always_ff @(posedge clk) begin
    if (frame_we) frame_mem[frame_waddr] <= frame_wdata;
    frame_q <= frame_mem[frame_raddr];
  end

  always_ff @(posedge clk) begin
    if (pass_we) pass_mem[dst_addr[AW-1:0]] <= {quo[2], quo[1], quo[0]};
    pass_q <= pass_mem[src_addr[AW-1:0]];
  end

  // window divider
  logic             div_start, div_done;
  logic [DEN_W-1:0] span;
  assign span = DEN_W'({br, 1'b1});

  tpbb_div #(.SUM_W(SUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (span),
    .num   (sum),
    .quo   (quo),
    .done  (div_done)
  );

  // next position after a write and end of the blur
  logic          x_last, y_last, blur_end;
  logic [PW-1:0] npos;

  always_comb begin
    x_last   = ({1'b0, x} + 1'b1) == {1'b0, bw};
    y_last   = ({1'b0, y} + 1'b1) == {1'b0, bh};
    blur_end = x_last && y_last && dir && (pass == PSW'(PASSES - 1));
    if (!x_last)      npos = dir ? y : x + 1'b1;
    else if (!y_last) npos = dir ? y + 1'b1 : '0;
    else              npos = '0;
  end

  // sequencer: read window, drain, divide, write back
  // each direction finishes its writes before the next reads the store
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE:   if (do_load && frame_full) state_next = ST_ACC;
      ST_ACC:    if (k == kend) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_DSTART;
      ST_DSTART: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV:    if (div_done) state_next = ST_WRITE;
      ST_WRITE:  state_next = blur_end ? ST_IDLE : ST_ACC;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // frame bookkeeping and blur counters
  always_ff @(posedge clk) begin
    if (rst) begin
      readout    <= 1'b0;
      load_count <= '0;
      read_count <= '0;
      rd_pend    <= 1'b0;
      dir        <= 1'b0;
      pass       <= '0;
      x          <= '0;
      y          <= '0;
      row_base   <= '0;
    end else begin
      rd_pend <= (state == ST_ACC);
      if (do_load) begin
        load_count <= load_count_next;
        if (frame_full) begin
          bw       <= eff_w;
          bh       <= eff_h;
          br       <= eff_r;
          dir      <= 1'b0;
          pass     <= '0;
          x        <= '0;
          y        <= '0;
          row_base <= '0;
          k        <= -$signed(KW'(eff_r));
          kend     <= $signed(KW'(eff_r));
        end
      end
      if (do_fetch && readout) begin
        if (fetch_last) begin
          readout    <= 1'b0;
          load_count <= '0;
          read_count <= '0;
        end else begin
          read_count <= read_count + 1'b1;
        end
      end
      if (state == ST_ACC && k != kend) k <= k + 1'b1;
      if (state == ST_WRITE) begin
        k    <= $signed(KW'(npos)) - $signed(KW'(br));
        kend <= $signed(KW'(npos)) + $signed(KW'(br));
        if (!x_last) begin
          x <= x + 1'b1;
        end else if (!y_last) begin
          x        <= '0;
          y        <= y + 1'b1;
          row_base <= row_base + CW'(bw);
        end else begin
          x        <= '0;
          y        <= '0;
          row_base <= '0;
          dir      <= !dir;
          if (dir) pass <= pass + 1'b1;
          if (blur_end) begin
            readout    <= 1'b1;
            read_count <= '0;
          end
        end
      end
    end
  end

  // window sums, cleared per output pixel
  logic [PIX_W-1:0] src_q;
  assign src_q = dir ? pass_q : frame_q;

  always_ff @(posedge clk) begin
    if ((do_load && frame_full) || state == ST_WRITE) begin
      sum <= '0;
    end else if (rd_pend) begin
      sum[2] <= sum[2] + SUM_W'(src_q[23:16]);
      sum[1] <= sum[1] + SUM_W'(src_q[15:8]);
      sum[0] <= sum[0] + SUM_W'(src_q[7:0]);
    end
  end

  // result register, store data follows in the cycle after the request
  logic out_valid, out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_strobe <= 1'b0;
      out_valid  <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      res_strobe <= do_fetch;
      out_valid  <= do_fetch && readout;
      out_last   <= do_fetch && readout && fetch_last;
    end
  end

  assign res.pixel_out = out_valid ? frame_q : '0;
  assign res.valid_res = out_valid;
  assign res.last      = out_last;

`ifndef ASSERT_OFF
  a_strobe_follows_fetch: assert property (@(posedge clk) disable iff (rst)
    res_strobe |-> $past(start && !busy && req.mode == MODE_FETCH))
    else $error("result strobe without a fetch request");

  a_readout_not_busy: assert property (@(posedge clk) disable iff (rst)
    readout |-> state == ST_IDLE)
    else $error("blur running during readout");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_last_needs_valid: assert property (@(posedge clk) disable iff (rst)
    res.last |-> res.valid_res && res_strobe)
    else $error("last flag on an invalid result");
`endif

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for two_pass_box_blur, directed and random requests
// predicts each fetch result from its own frame model and checks every res_strobe
// depends on tpbb_pkg and two_pass_box_blur
module testbench;
  import tpbb_pkg::*;

  localparam int MAXW = 128;
  localparam int MAXH = 128;
  localparam int MAXR = 15;
  localparam int NPASS = 2;
  localparam int DEPTH = MAXW * MAXH;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic res_strobe;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [7:0] cfg_data = '0;

  two_pass_box_blur dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .res_strobe(res_strobe), .res(res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // frame model state
  logic [23:0] img_mem [DEPTH];
  logic [23:0] row_mem [DEPTH];
  int unsigned loaded_px;
  int unsigned read_px;
  bit reading;
  logic [7:0] cur_w = 8'd128;
  logic [7:0] cur_h = 8'd128;
  logic [3:0] cur_r = 4'd4;

  res_t pending_px [$];
  int errors = 0;
  int sent = 0;
  bit allow_gaps = 1'b1;

  function automatic int eff_w();
    if (cur_w == 0) return 1;
    return (cur_w > MAXW) ? MAXW : cur_w;
  endfunction

  function automatic int eff_h();
    if (cur_h == 0) return 1;
    return (cur_h > MAXH) ? MAXH : cur_h;
  endfunction

  // one 1d window average over the three channels, edge samples clamped
  function automatic logic [23:0] window_avg(bit from_rows, int base, int stride,
                                             int pos, int n, int r);
    int sr, sg, sb, k, j, span;
    logic [23:0] px;
    sr = 0; sg = 0; sb = 0;
    span = 2 * r + 1;
    for (k = pos - r; k <= pos + r; k++) begin
      j = (k < 0) ? 0 : ((k >= n) ? n - 1 : k);
      px = from_rows ? row_mem[base + j * stride] : img_mem[base + j * stride];
      sr += px[23:16];
      sg += px[15:8];
      sb += px[7:0];
    end
    return {8'(sr / span), 8'(sg / span), 8'(sb / span)};
  endfunction

  task automatic blur_frame(int w, int h, int r);
    int p, x, y;
    for (p = 0; p < NPASS; p++) begin
      for (y = 0; y < h; y++)
        for (x = 0; x < w; x++)
          row_mem[y * w + x] = window_avg(1'b0, y * w, 1, x, w, r);
      for (y = 0; y < h; y++)
        for (x = 0; x < w; x++)
          img_mem[y * w + x] = window_avg(1'b1, x, w, y, h, r);
    end
  endtask

  // advance the model by one accepted request
  task automatic predict_blur(req_t rq);
    int w, h, total, idx;
    res_t r;
    w = eff_w();
    h = eff_h();
    total = w * h;
    if (rq.mode == MODE_LOAD) begin
      if (!reading) begin
        if (loaded_px < total) begin
          img_mem[loaded_px] = rq.pixel_in;
          loaded_px++;
        end
        if (loaded_px >= total) begin
          blur_frame(w, h, (cur_r > MAXR) ? MAXR : cur_r);
          reading = 1'b1;
          read_px = 0;
        end
      end
    end else if (!reading) begin
      r = '0;
      pending_px.push_back(r);
    end else begin
      idx = (read_px < total) ? read_px : total - 1;
      r.pixel_out = img_mem[idx];
      r.valid_res = 1'b1;
      r.last = (read_px + 1 >= total);
      pending_px.push_back(r);
      if (r.last) begin
        reading = 1'b0;
        loaded_px = 0;
        read_px = 0;
      end else begin
        read_px++;
      end
    end
  endtask

  // check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_strobe) begin
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res);
        errors++;
      end else begin
        if (res.pixel_out !== pending_px[0].pixel_out) begin
          $display("%0t: pixel_out expected %h actual %h", $time,
                   pending_px[0].pixel_out, res.pixel_out);
          errors++;
        end
        if (res.valid_res !== pending_px[0].valid_res) begin
          $display("%0t: valid_res expected %b actual %b", $time,
                   pending_px[0].valid_res, res.valid_res);
          errors++;
        end
        if (res.last !== pending_px[0].last) begin
          $display("%0t: last expected %b actual %b", $time,
                   pending_px[0].last, res.last);
          errors++;
        end
        void'(pending_px.pop_front());
      end
    end
  end

  // random sender gap
  task automatic maybe_gap();
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // send one request and wait for it to be taken
  task automatic send_req(logic mode, logic [23:0] pix);
    req_t rq;
    maybe_gap();
    rq.mode = mode;
    rq.pixel_in = pix;
    start <= 1'b1;
    req <= rq;
    do @(posedge clk); while (busy);
    predict_blur(rq);
    sent++;
  endtask

  // wait for results and any blur burst to finish
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH: cur_w = val;
      CFG_HEIGHT: cur_h = val;
      default: cur_r = val[3:0];
    endcase
  endtask

  task automatic set_frame(logic [7:0] w, logic [7:0] h, logic [7:0] r);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_RADIUS, r);
  endtask

  task automatic load_frame(int n);
    repeat (n) send_req(MODE_LOAD, 24'($urandom()));
  endtask

  task automatic read_frame(int n);
    repeat (n) send_req(MODE_FETCH, 24'($urandom()));
  endtask

  // early fetch, extreme pixels, dropped load during readout
  task automatic test_basic_frame();
    set_frame(8'd3, 8'd2, 8'd1);
    send_req(MODE_FETCH, 24'hFFFFFF);
    send_req(MODE_LOAD, 24'h000000);
    send_req(MODE_LOAD, 24'hFFFFFF);
    send_req(MODE_LOAD, 24'hFF0000);
    send_req(MODE_LOAD, 24'h00FF00);
    send_req(MODE_LOAD, 24'h0000FF);
    send_req(MODE_LOAD, 24'h123456);
    wait_quiet();
    send_req(MODE_FETCH, 24'h0);
    send_req(MODE_LOAD, 24'hABCDEF);
    read_frame(5);
    send_req(MODE_FETCH, 24'h0);
  endtask

  // zero sizes, oversize values, radius extremes
  task automatic test_size_limits();
    set_frame(8'd0, 8'd0, 8'd15);
    load_frame(1);
    read_frame(1);
    set_frame(8'd200, 8'd1, 8'd15);
    load_frame(128);
    read_frame(128);
    set_frame(8'd1, 8'd255, 8'd0);
    load_frame(128);
    read_frame(128);
  endtask

  // shrinking the frame mid-load completes it on the next load
  task automatic test_shrink_midload();
    set_frame(8'd4, 8'd4, 8'd2);
    load_frame(5);
    write_reg(CFG_WIDTH, 8'd1);
    write_reg(CFG_HEIGHT, 8'd2);
    load_frame(1);
    read_frame(2);
  endtask

  // random small frames with stray requests
  task automatic test_random_frames();
    int w, h, total, i, target;
    bit held_off;
    target = sent + 300;
    held_off = 1'b0;
    while (sent < target) begin
      if (target - sent < 150) allow_gaps = 1'b0;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 128) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 12);
      if (w * h > 160) h = 1;
      set_frame(8'(w), 8'(h), 8'($urandom_range(0, 15)));
      total = w * h;
      for (i = 0; i < total; i++) begin
        if ($urandom_range(0, 9) == 0) send_req(MODE_FETCH, 24'($urandom()));
        if (!held_off && i == total / 2) begin
          // hold the sender until everything expected has come back
          start <= 1'b0;
          @(posedge clk);
          while (pending_px.size() != 0) @(posedge clk);
          held_off = 1'b1;
        end
        send_req(MODE_LOAD, 24'($urandom()));
      end
      for (i = 0; i < total; i++) begin
        if ($urandom_range(0, 9) == 0) send_req(MODE_LOAD, 24'($urandom()));
        send_req(MODE_FETCH, 24'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    loaded_px = 0;
    read_px = 0;
    reading = 1'b0;
    test_basic_frame();
    test_size_limits();
    test_shrink_midload();
    test_random_frames();
    start <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: files.f
sv/tpbb_pkg.sv
sv/tpbb_div.sv
sv/two_pass_box_blur.sv
sim/testbench.sv
